// ===== src/cbp_pkg.sv =====
package cbp_pkg;

  // frame geometry
  localparam logic [10:0] FrameW    = 11'd1920;
  localparam logic [10:0] FrameH    = 11'd1080;
  localparam logic [10:0] BarRows   = 11'd630;
  localparam logic [10:0] Strip2End = 11'd720;
  localparam logic [10:0] Strip3End = 11'd810;

  // alpha band row boundaries, 126 rows per band
  localparam logic [10:0] Band1Row = 11'd126;
  localparam logic [10:0] Band2Row = 11'd252;
  localparam logic [10:0] Band3Row = 11'd378;
  localparam logic [10:0] Band4Row = 11'd504;

  // column boundaries
  localparam logic [10:0] EdgeL  = 11'd240;
  localparam logic [10:0] EdgeR  = 11'd1680;
  localparam logic [10:0] Bar2X  = 11'd445;
  localparam logic [10:0] Bar3X  = 11'd651;
  localparam logic [10:0] Bar4X  = 11'd857;
  localparam logic [10:0] Bar5X  = 11'd1063;
  localparam logic [10:0] Bar6X  = 11'd1269;
  localparam logic [10:0] Bar7X  = 11'd1475;
  localparam logic [10:0] PlgW0  = 11'd549;
  localparam logic [10:0] PlgB1  = 11'd960;
  localparam logic [10:0] PlgL5  = 11'd1268;
  localparam logic [10:0] PlgB2  = 11'd1337;
  localparam logic [10:0] PlgL10 = 11'd1405;
  localparam logic [10:0] PlgB3  = 11'd1474;

  // levels
  localparam logic [7:0] LvlPillar = 8'd102;
  localparam logic [7:0] LvlBar    = 8'd192;
  localparam logic [7:0] LvlFull   = 8'd255;
  localparam logic [7:0] LvlIRed   = 8'd104;
  localparam logic [7:0] LvlIGreen = 8'd42;
  localparam logic [7:0] LvlPlgSide = 8'd38;
  localparam logic [7:0] LvlPlg5   = 8'd5;
  localparam logic [7:0] LvlPlg10  = 8'd10;

  // alpha per band
  localparam logic [7:0] Alpha0 = 8'd255;
  localparam logic [7:0] Alpha1 = 8'd191;
  localparam logic [7:0] Alpha2 = 8'd127;
  localparam logic [7:0] Alpha3 = 8'd63;
  localparam logic [7:0] Alpha4 = 8'd0;

  // ramp: (d*255)/1440 = ((d*17) >> 5) / 3, the /3 as *683 >> 11
  localparam logic [14:0] RampMul  = 15'd17;
  localparam logic [19:0] RecipTh  = 20'd683;

endpackage

// ===== src/color_bar_pattern_pixel.sv =====
// Color bar test pattern pixel generator. Each request carries a pixel
// coordinate (in_col, in_row) of a 1920x1080 frame and returns the RGBA
// color of an SMPTE-like bar pattern at that point: five alpha-faded bar
// bands in rows 0..629, the cyan/+I/white/blue strip, the yellow/gray
// ramp/red strip and the PLUGE strip below. Coordinates outside the frame
// give all-zero RGBA. The block is a two-register pipeline (input register,
// result register) with the color lookup done combinationally between them;
// a request passes through both registers to the outputs, and one request is
// taken every cycle as long as out_stall stays low. No configuration, no state.
module color_bar_pattern_pixel (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [10:0] in_col,
  input  logic [10:0] in_row,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_alpha
);

  logic        s1_valid_r;
  logic [10:0] s1_col_r;
  logic [10:0] s1_row_r;
  logic        out_valid_r;
  logic [7:0]  red_r, green_r, blue_r, alpha_r;
  logic [7:0]  red_nxt, green_nxt, blue_nxt, alpha_nxt;
  logic        s1_adv;
  logic        in_take;

  // ramp datapath
  logic [10:0] ramp_d;
  logic [14:0] ramp_p;
  logic [19:0] ramp_m;
  logic [7:0]  ramp_v;
  logic [7:0]  band_alpha;
  logic [7:0]  plg_v;

  // pipeline flow control
  assign s1_adv   = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_take  = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_col_r <= in_col;
      s1_row_r <= in_row;
    end
  end

  // gray ramp level
  assign ramp_d = s1_col_r - cbp_pkg::EdgeL;
  assign ramp_p = {4'd0, ramp_d} * cbp_pkg::RampMul;
  assign ramp_m = {10'd0, ramp_p[14:5]} * cbp_pkg::RecipTh;
  assign ramp_v = ramp_m[18:11];

  // alpha by row band
  always_comb begin
    if (s1_row_r < cbp_pkg::Band1Row) begin
      band_alpha = cbp_pkg::Alpha0;
    end else if (s1_row_r < cbp_pkg::Band2Row) begin
      band_alpha = cbp_pkg::Alpha1;
    end else if (s1_row_r < cbp_pkg::Band3Row) begin
      band_alpha = cbp_pkg::Alpha2;
    end else if (s1_row_r < cbp_pkg::Band4Row) begin
      band_alpha = cbp_pkg::Alpha3;
    end else begin
      band_alpha = cbp_pkg::Alpha4;
    end
  end

  // pluge level by column
  always_comb begin
    if (s1_col_r < cbp_pkg::EdgeL || s1_col_r >= cbp_pkg::EdgeR) begin
      plg_v = cbp_pkg::LvlPlgSide;
    end else if (s1_col_r < cbp_pkg::PlgW0) begin
      plg_v = 8'd0;
    end else if (s1_col_r < cbp_pkg::PlgB1) begin
      plg_v = cbp_pkg::LvlFull;
    end else if (s1_col_r < cbp_pkg::PlgL5) begin
      plg_v = 8'd0;
    end else if (s1_col_r < cbp_pkg::PlgB2) begin
      plg_v = cbp_pkg::LvlPlg5;
    end else if (s1_col_r < cbp_pkg::PlgL10) begin
      plg_v = 8'd0;
    end else if (s1_col_r < cbp_pkg::PlgB3) begin
      plg_v = cbp_pkg::LvlPlg10;
    end else begin
      plg_v = 8'd0;
    end
  end

  // pixel color selection
  always_comb begin
    red_nxt   = 8'd0;
    green_nxt = 8'd0;
    blue_nxt  = 8'd0;
    alpha_nxt = cbp_pkg::LvlFull;
    if (s1_col_r >= cbp_pkg::FrameW || s1_row_r >= cbp_pkg::FrameH) begin
      alpha_nxt = 8'd0;
    end else if (s1_row_r < cbp_pkg::BarRows) begin
      alpha_nxt = band_alpha;
      if (s1_col_r < cbp_pkg::EdgeL || s1_col_r >= cbp_pkg::EdgeR) begin
        red_nxt   = cbp_pkg::LvlPillar;
        green_nxt = cbp_pkg::LvlPillar;
        blue_nxt  = cbp_pkg::LvlPillar;
      end else if (s1_col_r < cbp_pkg::Bar2X) begin
        red_nxt   = cbp_pkg::LvlBar;
        green_nxt = cbp_pkg::LvlBar;
        blue_nxt  = cbp_pkg::LvlBar;
      end else if (s1_col_r < cbp_pkg::Bar3X) begin
        red_nxt   = cbp_pkg::LvlBar;
        green_nxt = cbp_pkg::LvlBar;
      end else if (s1_col_r < cbp_pkg::Bar4X) begin
        green_nxt = cbp_pkg::LvlBar;
        blue_nxt  = cbp_pkg::LvlBar;
      end else if (s1_col_r < cbp_pkg::Bar5X) begin
        green_nxt = cbp_pkg::LvlBar;
      end else if (s1_col_r < cbp_pkg::Bar6X) begin
        red_nxt   = cbp_pkg::LvlBar;
        blue_nxt  = cbp_pkg::LvlBar;
      end else if (s1_col_r < cbp_pkg::Bar7X) begin
        red_nxt   = cbp_pkg::LvlBar;
      end else begin
        blue_nxt  = cbp_pkg::LvlBar;
      end
    end else if (s1_row_r < cbp_pkg::Strip2End) begin
      if (s1_col_r < cbp_pkg::EdgeL) begin
        green_nxt = cbp_pkg::LvlFull;
        blue_nxt  = cbp_pkg::LvlFull;
      end else if (s1_col_r < cbp_pkg::Bar2X) begin
        red_nxt   = cbp_pkg::LvlIRed;
        green_nxt = cbp_pkg::LvlIGreen;
      end else if (s1_col_r < cbp_pkg::EdgeR) begin
        red_nxt   = cbp_pkg::LvlBar;
        green_nxt = cbp_pkg::LvlBar;
        blue_nxt  = cbp_pkg::LvlBar;
      end else begin
        blue_nxt  = cbp_pkg::LvlFull;
      end
    end else if (s1_row_r < cbp_pkg::Strip3End) begin
      if (s1_col_r < cbp_pkg::EdgeL) begin
        red_nxt   = cbp_pkg::LvlFull;
        green_nxt = cbp_pkg::LvlFull;
      end else if (s1_col_r < cbp_pkg::EdgeR) begin
        red_nxt   = ramp_v;
        green_nxt = ramp_v;
        blue_nxt  = ramp_v;
      end else begin
        red_nxt   = cbp_pkg::LvlFull;
      end
    end else begin
      red_nxt   = plg_v;
      green_nxt = plg_v;
      blue_nxt  = plg_v;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
      alpha_r <= alpha_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_red   = red_r;
  assign out_green = green_r;
  assign out_blue  = blue_r;
  assign out_alpha = alpha_r;

`ifndef SYNTH
  // input side only holds off when both stages are full and the output is stalled
  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled while pipeline has room");

  // a taken request reaches the input register
  a_take_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> s1_valid_r)
    else $error("accepted request lost at input register");

  // an input-register item moving on becomes a valid result
  a_s1_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_adv) |=> out_valid_r)
    else $error("item lost between stages");

  // pluge rows give a neutral gray
  a_pluge_gray: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_adv && s1_row_r >= cbp_pkg::Strip3End &&
     s1_row_r < cbp_pkg::FrameH && s1_col_r < cbp_pkg::FrameW)
    |=> (out_red == out_green && out_green == out_blue))
    else $error("pluge pixel not gray");

  // off-frame coordinates are transparent
  a_offframe_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_adv && s1_col_r >= cbp_pkg::FrameW)
    |=> (out_alpha == 8'd0 && out_red == 8'd0))
    else $error("off-frame pixel not zero");
`endif

endmodule

// ===== dv/cbp_pixel_checker.sv =====
`timescale 1ns / 1ps

module cbp_pixel_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [10:0] in_col,
  input  logic [10:0] in_row,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_red,
  input  logic [7:0]  out_green,
  input  logic [7:0]  out_blue,
  input  logic [7:0]  out_alpha,
  output int          err_count,
  output int          pending
);

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } rgba_t;

  // colors still owed by the block, oldest first
  rgba_t owed_px[$];

  initial begin
    err_count = 0;
    pending   = 0;
  end

  // color of the test pattern at one coordinate
  function automatic rgba_t pattern_pixel(logic [10:0] col, logic [10:0] row);
    rgba_t       px;
    logic [7:0]  a;
    logic [7:0]  lvl;
    logic [7:0]  bar;
    logic [7:0]  full;
    int unsigned ramp;
    px   = '0;
    bar  = cbp_pkg::LvlBar;
    full = cbp_pkg::LvlFull;
    if (col >= cbp_pkg::FrameW || row >= cbp_pkg::FrameH) begin
      px = '0;
    end else if (row < cbp_pkg::BarRows) begin
      // alpha fades by band of rows
      if (row < cbp_pkg::Band1Row)      a = cbp_pkg::Alpha0;
      else if (row < cbp_pkg::Band2Row) a = cbp_pkg::Alpha1;
      else if (row < cbp_pkg::Band3Row) a = cbp_pkg::Alpha2;
      else if (row < cbp_pkg::Band4Row) a = cbp_pkg::Alpha3;
      else                              a = cbp_pkg::Alpha4;
      if (col < cbp_pkg::EdgeL || col >= cbp_pkg::EdgeR)
        px = {cbp_pkg::LvlPillar, cbp_pkg::LvlPillar, cbp_pkg::LvlPillar, a};
      else if (col < cbp_pkg::Bar2X) px = {bar, bar, bar, a};
      else if (col < cbp_pkg::Bar3X) px = {bar, bar, 8'd0, a};
      else if (col < cbp_pkg::Bar4X) px = {8'd0, bar, bar, a};
      else if (col < cbp_pkg::Bar5X) px = {8'd0, bar, 8'd0, a};
      else if (col < cbp_pkg::Bar6X) px = {bar, 8'd0, bar, a};
      else if (col < cbp_pkg::Bar7X) px = {bar, 8'd0, 8'd0, a};
      else                           px = {8'd0, 8'd0, bar, a};
    end else if (row < cbp_pkg::Strip2End) begin
      // cyan, +I, white, blue
      if (col < cbp_pkg::EdgeL)
        px = {8'd0, full, full, full};
      else if (col < cbp_pkg::Bar2X)
        px = {cbp_pkg::LvlIRed, cbp_pkg::LvlIGreen, 8'd0, full};
      else if (col < cbp_pkg::EdgeR)
        px = {bar, bar, bar, full};
      else
        px = {8'd0, 8'd0, full, full};
    end else if (row < cbp_pkg::Strip3End) begin
      // yellow, gray ramp, red
      if (col < cbp_pkg::EdgeL) begin
        px = {full, full, 8'd0, full};
      end else if (col < cbp_pkg::EdgeR) begin
        ramp = (int'(col) - int'(cbp_pkg::EdgeL)) * 255 / 1440;
        lvl  = ramp[7:0];
        px   = {lvl, lvl, lvl, full};
      end else begin
        px = {full, 8'd0, 8'd0, full};
      end
    end else begin
      // pluge black-level strip
      if (col < cbp_pkg::EdgeL || col >= cbp_pkg::EdgeR) lvl = cbp_pkg::LvlPlgSide;
      else if (col < cbp_pkg::PlgW0)                     lvl = 8'd0;
      else if (col < cbp_pkg::PlgB1)                     lvl = full;
      else if (col < cbp_pkg::PlgL5)                     lvl = 8'd0;
      else if (col < cbp_pkg::PlgB2)                     lvl = cbp_pkg::LvlPlg5;
      else if (col < cbp_pkg::PlgL10)                    lvl = 8'd0;
      else if (col < cbp_pkg::PlgB3)                     lvl = cbp_pkg::LvlPlg10;
      else                                               lvl = 8'd0;
      px = {lvl, lvl, lvl, full};
    end
    return px;
  endfunction

  // predict on each request, compare on each result
  always @(posedge clk) begin
    rgba_t want;
    rgba_t got;
    if (rst_n) begin
      if (in_valid && !in_stall) owed_px.push_back(pattern_pixel(in_col, in_row));
      if (out_valid && !out_stall) begin
        got = {out_red, out_green, out_blue, out_alpha};
        if (owed_px.size() == 0) begin
          if (err_count < 10)
            $display("%0t: unexpected pixel r=%0d g=%0d b=%0d a=%0d", $realtime,
                     got.red, got.green, got.blue, got.alpha);
          err_count++;
        end else begin
          want = owed_px.pop_front();
          if (got.red !== want.red || got.green !== want.green ||
              got.blue !== want.blue || got.alpha !== want.alpha) begin
            if (err_count < 10)
              $display({"%0t: pixel mismatch exp r=%0d g=%0d b=%0d a=%0d",
                        " got r=%0d g=%0d b=%0d a=%0d"},
                       $realtime, want.red, want.green, want.blue, want.alpha,
                       got.red, got.green, got.blue, got.alpha);
            err_count++;
          end
        end
      end
    end
    pending = owed_px.size();
  end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int CycleLimit = 60000;
  localparam int NumRandom  = 400;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  logic [10:0] in_col    = '0;
  logic [10:0] in_row    = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic [7:0]  out_alpha;

  int err_count;
  int pending;
  int cycles     = 0;
  int stall_left = 0;
  bit calm       = 1'b0;

  color_bar_pattern_pixel i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_col    (in_col),
    .in_row    (in_row),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue),
    .out_alpha (out_alpha)
  );

  cbp_pixel_checker i_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_col    (in_col),
    .in_row    (in_row),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue),
    .out_alpha (out_alpha),
    .err_count (err_count),
    .pending   (pending)
  );

  always #5 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // receiver back-pressure in random bursts
  always @(negedge clk) begin
    if (!rst_n || calm) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left = $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // column edges of bars, strips and pluge levels
  function automatic int col_edge(int idx);
    case (idx)
      0:       return 0;
      1:       return 240;
      2:       return 445;
      3:       return 651;
      4:       return 857;
      5:       return 1063;
      6:       return 1269;
      7:       return 1475;
      8:       return 549;
      9:       return 960;
      10:      return 1268;
      11:      return 1337;
      12:      return 1405;
      13:      return 1474;
      14:      return 1680;
      default: return 1920;
    endcase
  endfunction

  // row edges of alpha bands and strips
  function automatic int row_edge(int idx);
    case (idx)
      0:       return 0;
      1:       return 126;
      2:       return 252;
      3:       return 378;
      4:       return 504;
      5:       return 630;
      6:       return 720;
      7:       return 810;
      default: return 1080;
    endcase
  endfunction

  // mostly in-frame, some near edges, some anywhere in 11 bits
  function automatic logic [10:0] pick_col();
    int k;
    int c;
    k = $urandom_range(0, 19);
    if (k < 14)      c = $urandom_range(0, 1919);
    else if (k < 17) c = col_edge($urandom_range(0, 15)) + $urandom_range(0, 2) - 1;
    else             c = $urandom_range(0, 2047);
    return c[10:0];
  endfunction

  function automatic logic [10:0] pick_row();
    int k;
    int r;
    k = $urandom_range(0, 19);
    if (k < 14)      r = $urandom_range(0, 1079);
    else if (k < 17) r = row_edge($urandom_range(0, 8)) + $urandom_range(0, 2) - 1;
    else             r = $urandom_range(0, 2047);
    return r[10:0];
  endfunction

  // present one request and hold it until taken, return at the next falling edge
  task automatic send_pixel(logic [10:0] col, logic [10:0] row);
    in_valid <= 1'b1;
    in_col   <= col;
    in_row   <= row;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // sender gap, now and then
  task automatic maybe_gap();
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
  endtask

  // hold off until every owed pixel has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: frame corners, band and bar edges, strips, pluge levels, outside
    send_pixel(11'd0, 11'd0);
    send_pixel(11'd1919, 11'd0);
    send_pixel(11'd240, 11'd125);
    send_pixel(11'd239, 11'd126);
    send_pixel(11'd444, 11'd252);
    maybe_gap();
    send_pixel(11'd445, 11'd378);
    send_pixel(11'd650, 11'd504);
    send_pixel(11'd857, 11'd629);
    send_pixel(11'd1063, 11'd629);
    send_pixel(11'd1475, 11'd629);
    send_pixel(11'd239, 11'd630);
    send_pixel(11'd444, 11'd719);
    send_pixel(11'd1680, 11'd719);
    maybe_gap();
    send_pixel(11'd0, 11'd720);
    send_pixel(11'd240, 11'd720);
    send_pixel(11'd1679, 11'd809);
    send_pixel(11'd1680, 11'd809);
    send_pixel(11'd239, 11'd810);
    send_pixel(11'd549, 11'd1000);
    send_pixel(11'd1268, 11'd900);
    send_pixel(11'd1405, 11'd1079);
    send_pixel(11'd1474, 11'd850);
    send_pixel(11'd1920, 11'd500);
    send_pixel(11'd100, 11'd1080);
    send_pixel(11'd2047, 11'd2047);
    drain();

    // random coordinates with gaps and back-pressure
    for (int i = 0; i < NumRandom; i++) begin
      if (i == NumRandom / 2) drain();
      if (i == NumRandom - 60) calm = 1'b1;
      maybe_gap();
      send_pixel(pick_col(), pick_row());
    end

    // wind down
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(posedge clk);
    if (err_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
